FILE: hdl/tlbpt_pkg.sv
package tlbpt_pkg;

    // fixed field widths of the item ports
    localparam int VA_W   = 24;
    localparam int PHYS_W = 20;

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    // where the frame number of a result came from
    typedef enum logic [1:0] {
        SRC_TLB     = 2'd0,
        SRC_TABLE   = 2'd1,
        SRC_FAULT   = 2'd2,
        SRC_ILLEGAL = 2'd3
    } t_source;

    // decision of the resolve stage, consumed by the controller
    typedef struct packed {
        logic    tlb_we;
        logic    pt_we;
        t_source source;
    } t_update;

endpackage

FILE: hdl/tlb_page_table_translate_core.sv
// Address translator: a direct-mapped TLB in front of a single-level page table, both held
// in synchronous RAMs whose entries carry their own valid bit. An item's RAM reads are issued
// in the cycle it is accepted; from the registered read data the hit / table / fault decision
// is made, and once the output register is free or being drained the TLB and page table are
// written back and the result is loaded into the output register; only one item is in
// flight, so a read never meets a pending write to the same entry. A result waiting in the
// output register does not block the next lookup, only its completion. After reset a clearing
// pass writes every entry of both RAMs, one address a cycle, and no item is accepted until it
// ends. TLB_DEPTH and PAGE_TABLE_DEPTH must be powers of two; the block does not enforce it.
module tlb_page_table_translate_core #(
    parameter int TLB_DEPTH        = 16,
    parameter int PAGE_TABLE_DEPTH = 512,
    parameter int FRAME_BITS       = 11,
    parameter int OFFSET_BITS      = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tlbpt_pkg::VA_W-1:0]   i_virt_address,
    input  logic [FRAME_BITS-1:0]        i_fault_frame,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tlbpt_pkg::PHYS_W-1:0] o_phys_addr,
    output logic [1:0]                   o_source
);

    import tlbpt_pkg::*;

    localparam int VPN_W       = $clog2(PAGE_TABLE_DEPTH);
    localparam int TLB_AW      = $clog2(TLB_DEPTH);
    localparam int TAG_W       = (VPN_W > TLB_AW) ? (VPN_W - TLB_AW) : 1;
    localparam int VPN_EXT_W   = VPN_W + TLB_AW + 1;
    localparam int MAX_DEPTH   = (TLB_DEPTH > PAGE_TABLE_DEPTH) ? TLB_DEPTH : PAGE_TABLE_DEPTH;
    localparam int CLR_AW      = $clog2(MAX_DEPTH);
    localparam int TLB_DW      = 1 + TAG_W + FRAME_BITS;
    localparam int PT_DW       = 1 + FRAME_BITS;
    localparam int LEGAL_SHIFT = OFFSET_BITS + VPN_W;
    localparam int PA_W        = FRAME_BITS + OFFSET_BITS;

    t_state r_state, n_state;

    logic [CLR_AW-1:0] r_clr_idx;
    logic              clr_done;

    // item registers
    logic                   r_illegal;
    logic [VPN_W-1:0]       r_vpn;
    logic [TLB_AW-1:0]      r_slot;
    logic [TAG_W-1:0]       r_tag;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [FRAME_BITS-1:0]  r_fault_frame;

    // input decode
    logic                 in_illegal;
    logic [VPN_W-1:0]     in_vpn;
    logic [VPN_EXT_W-1:0] in_vpn_ext;
    logic                 in_accept;

    // ram ports
    logic              tlb_we, pt_we, rd_en;
    logic [TLB_AW-1:0] tlb_wr_addr;
    logic [VPN_W-1:0]  pt_wr_addr;
    logic [TLB_DW-1:0] tlb_wr_data, tlb_rd_data;
    logic [PT_DW-1:0]  pt_wr_data, pt_rd_data;

    // resolve results
    logic [FRAME_BITS-1:0] frame;
    t_update               upd;
    logic                  advance;
    logic [PA_W-1:0]       pa_wide;

    // output register
    logic              r_out_valid;
    logic [PHYS_W-1:0] r_phys;
    t_source           r_source;

    // split the incoming address
    assign in_illegal = (i_virt_address >> LEGAL_SHIFT) != '0;
    assign in_vpn     = VPN_W'(i_virt_address >> OFFSET_BITS);
    assign in_vpn_ext = VPN_EXT_W'(in_vpn);
    assign in_accept  = i_in_valid && o_in_ready;
    assign clr_done   = (r_clr_idx == CLR_AW'(MAX_DEPTH - 1));
    assign advance    = (r_state == S_LOOKUP) && (!r_out_valid || i_out_ready);

    // state register and clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + CLR_AW'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (clr_done)  n_state = S_IDLE;
            S_IDLE:   if (in_accept) n_state = S_LOOKUP;
            S_LOOKUP: if (advance)   n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // controller outputs: ram writes are the clear sweep or the writeback
    always_comb begin
        o_in_ready  = 1'b0;
        rd_en       = 1'b0;
        tlb_we      = 1'b0;
        pt_we       = 1'b0;
        tlb_wr_addr = r_slot;
        pt_wr_addr  = r_vpn;
        tlb_wr_data = {1'b1, r_tag, frame};
        pt_wr_data  = {1'b1, r_fault_frame};
        case (r_state)
            S_CLEAR: begin
                tlb_we      = 1'b1;
                pt_we       = 1'b1;
                tlb_wr_addr = r_clr_idx[TLB_AW-1:0];
                pt_wr_addr  = r_clr_idx[VPN_W-1:0];
                tlb_wr_data = '0;
                pt_wr_data  = '0;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                rd_en      = i_in_valid;
            end
            S_LOOKUP: begin
                tlb_we = advance && upd.tlb_we;
                pt_we  = advance && upd.pt_we;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // capture the item
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_illegal     <= in_illegal;
            r_vpn         <= in_vpn;
            r_slot        <= in_vpn_ext[TLB_AW-1:0];
            r_tag         <= in_vpn_ext[TLB_AW +: TAG_W];
            r_offset      <= i_virt_address[OFFSET_BITS-1:0];
            r_fault_frame <= i_fault_frame;
        end
    end

    // tlb ram: valid, tag, frame
    tlbpt_ram #(
        .WIDTH (TLB_DW),
        .DEPTH (TLB_DEPTH)
    ) u_tlb_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tlb_we),
        .i_wr_addr (tlb_wr_addr),
        .i_wr_data (tlb_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (in_vpn_ext[TLB_AW-1:0]),
        .o_rd_data (tlb_rd_data)
    );

    // page table ram: valid, frame
    tlbpt_ram #(
        .WIDTH (PT_DW),
        .DEPTH (PAGE_TABLE_DEPTH)
    ) u_pt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pt_we),
        .i_wr_addr (pt_wr_addr),
        .i_wr_data (pt_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (in_vpn),
        .o_rd_data (pt_rd_data)
    );

    // hit / table / fault decision
    tlbpt_resolve #(
        .TAG_W      (TAG_W),
        .FRAME_BITS (FRAME_BITS)
    ) u_resolve (
        .i_illegal     (r_illegal),
        .i_tag         (r_tag),
        .i_fault_frame (r_fault_frame),
        .i_tlb_valid   (tlb_rd_data[TLB_DW-1]),
        .i_tlb_tag     (tlb_rd_data[FRAME_BITS +: TAG_W]),
        .i_tlb_frame   (tlb_rd_data[FRAME_BITS-1:0]),
        .i_pt_valid    (pt_rd_data[PT_DW-1]),
        .i_pt_frame    (pt_rd_data[FRAME_BITS-1:0]),
        .o_frame       (frame),
        .o_update      (upd)
    );

    assign pa_wide = {frame, r_offset};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_phys   <= r_illegal ? '0 : PHYS_W'(pa_wide);
            r_source <= upd.source;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_phys_addr = r_phys;
    assign o_source    = r_source;

endmodule

FILE: hdl/tlbpt_ram.sv
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/tlbpt_resolve.sv
module tlbpt_resolve #(
    parameter int TAG_W      = 5,
    parameter int FRAME_BITS = 11
) (
    input  logic                    i_illegal,
    input  logic [TAG_W-1:0]        i_tag,
    input  logic [FRAME_BITS-1:0]   i_fault_frame,
    input  logic                    i_tlb_valid,
    input  logic [TAG_W-1:0]        i_tlb_tag,
    input  logic [FRAME_BITS-1:0]   i_tlb_frame,
    input  logic                    i_pt_valid,
    input  logic [FRAME_BITS-1:0]   i_pt_frame,
    output logic [FRAME_BITS-1:0]   o_frame,
    output tlbpt_pkg::t_update      o_update
);

    import tlbpt_pkg::*;

    // illegal first, then tlb hit, then page table, then fault with the supplied frame
    always_comb begin
        o_frame         = '0;
        o_update.tlb_we = 1'b0;
        o_update.pt_we  = 1'b0;
        o_update.source = SRC_ILLEGAL;
        if (i_illegal) begin
            o_update.source = SRC_ILLEGAL;
        end else if (i_tlb_valid && (i_tlb_tag == i_tag)) begin
            o_frame         = i_tlb_frame;
            o_update.source = SRC_TLB;
        end else if (i_pt_valid) begin
            o_frame         = i_pt_frame;
            o_update.tlb_we = 1'b1;
            o_update.source = SRC_TABLE;
        end else begin
            o_frame         = i_fault_frame;
            o_update.tlb_we = 1'b1;
            o_update.pt_we  = 1'b1;
            o_update.source = SRC_FAULT;
        end
    end

endmodule
